// File: hw/rtl/ile_pkg.sv
package ile_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the request and result streams.
    localparam int MODE_W   = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int TDATA_W  = 40;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_POS   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LIST_FULL = 2'd2;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic             ins_en;
        logic             del_en;
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/ile_cell.sv
module ile_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CMP_W      = 5,
    parameter int IDX        = 0
) (
    input  logic                   clk,
    input  ile_pkg::cell_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0]  in_value,
    input  logic [DATA_WIDTH-1:0]  prev_data,
    input  logic [DATA_WIDTH-1:0]  next_data,
    output logic [DATA_WIDTH-1:0]  data,
    output logic [DATA_WIDTH-1:0]  rd_term
);
    import ile_pkg::*;

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [CMP_W-1:0]      pos_ext;

    assign pos_ext = CMP_W'(ctrl.pos);

    // An insert pulls from the left neighbor past the position, a delete from the right.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins_en)
        begin
            if (MY_IDX == pos_ext)
            begin
                data_next = in_value;
            end
            else if (MY_IDX > pos_ext)
            begin
                data_next = prev_data;
            end
        end
        else if (ctrl.del_en && (MY_IDX >= pos_ext))
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_term = (MY_IDX == pos_ext) ? data_reg : '0;

endmodule

// File: hw/rtl/indexed_list_engine_unit.sv
// A request's result is registered at the edge that accepts it and is on m_tdata right after.
// Throughput: one request per cycle unless a held output stalls s_tready; each request is done
// when the row of cells shifts, so the next may follow at once while the output is drained.
// Reset (rst_n low, asynchronous) empties the list and drops the output valid;
// the cell contents are not cleared.
module indexed_list_engine_unit #(
    parameter int CAPACITY   = ile_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // mode[1:0], position[6:2], value[38:7], zero pad [39]
    input  logic [ile_pkg::TDATA_W-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // read_value[31:0], status[33:32], entry_count[38:34], zero pad [39]
    output logic [ile_pkg::TDATA_W-1:0] m_tdata
);
    import ile_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [MODE_W-1:0]     mode;
    logic [POS_W-1:0]      position;
    logic [VALUE_W-1:0]    value;
    logic [63:0]           value_wide;
    logic [DATA_WIDTH-1:0] store_word;

    logic                  accept;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  full;
    logic                  ins_ok;
    logic                  del_ok;
    logic                  rd_ok;
    logic [STATUS_W-1:0]   status;
    cell_ctrl_t            ctrl;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_terms  [CAPACITY];
    logic signed [DATA_WIDTH-1:0] rd_word;
    logic [63:0]           rd_wide;
    logic [VALUE_W-1:0]    read_value;

    logic                  m_tvalid_reg;
    logic [VALUE_W-1:0]    read_value_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [COUNT_W-1:0]    entry_count_reg;

    assign mode       = s_tdata[1:0];
    assign position   = s_tdata[6:2];
    assign value      = s_tdata[38:7];
    assign value_wide = {{32{value[31]}}, value};
    assign store_word = value_wide[DATA_WIDTH-1:0];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        ins_ok = 1'b0;
        del_ok = 1'b0;
        rd_ok  = 1'b0;
        status = STATUS_OK;
        case (mode)
            MODE_INSERT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    status = STATUS_BAD_POS;
                end
                else if (full)
                begin
                    status = STATUS_LIST_FULL;
                end
                else
                begin
                    ins_ok = 1'b1;
                end
            end
            MODE_DELETE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status = STATUS_BAD_POS;
                end
                else
                begin
                    del_ok = 1'b1;
                end
            end
            MODE_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status = STATUS_BAD_POS;
                end
                else
                begin
                    rd_ok = 1'b1;
                end
            end
            default:
            begin
                status = STATUS_BAD_POS;
            end
        endcase
    end

    assign ctrl.ins_en = accept && ins_ok;
    assign ctrl.del_en = accept && del_ok;
    assign ctrl.pos    = position;

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] prev_d;
            logic [DATA_WIDTH-1:0] next_d;
            if (gi == 0)
            begin : g_first
                assign prev_d = '0;
            end
            else
            begin : g_mid_l
                assign prev_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_d = '0;
            end
            else
            begin : g_mid_r
                assign next_d = cell_data[gi+1];
            end

            ile_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CMP_W      (CMP_W),
                .IDX        (gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .in_value  (store_word),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (cell_data[gi]),
                .rd_term   (rd_terms[gi])
            );
        end
    endgenerate

    // Only the addressed cell drives a nonzero term onto the read bus.
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_word = rd_word | rd_terms[i];
        end
    end

    assign rd_wide    = 64'(rd_word);
    assign read_value = rd_ok ? rd_wide[VALUE_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg  <= read_value;
            status_reg      <= status;
            entry_count_reg <= COUNT_W'(count_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, entry_count_reg, status_reg, read_value_reg};

endmodule

// File: hw/rtl/ile_checker.sv
module ile_checker #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [ile_pkg::TDATA_W-1:0] m_tdata
);
    import ile_pkg::*;

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[33:32] <= STATUS_LIST_FULL))
        else $error("undefined status code");

    // A failed request never returns data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] != STATUS_OK) |-> (m_tdata[31:0] == '0))
        else $error("nonzero read value on a failed request");

    // A full-list refusal only comes when the count is at capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] == STATUS_LIST_FULL)
            |-> (m_tdata[38:34] == COUNT_W'(CAPACITY)))
        else $error("list full reported below capacity");

endmodule

bind indexed_list_engine_unit ile_checker #(.CAPACITY(CAPACITY)) u_ile_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
